// File: design/sensor_frame_deframer_top_macros.svh
// Assertion macros shared by the sensor frame deframer modules.
`ifndef SENSOR_FRAME_DEFRAMER_TOP_MACROS_SVH
`define SENSOR_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/sfd_pkg.sv
// Shared constants and controller/datapath interface types of the deframer.
`default_nettype none

package sfd_pkg;

   localparam int NUM_WORDS      = 12;
   localparam int BYTES_PER_WORD = 4;

   localparam int BYTE_W        = 8;
   localparam int WORD_W        = 32;
   localparam int INDEX_W       = 4;
   localparam int CSR_INDEX_W   = 2;
   localparam int WORD_IDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BYTE_CNT_W    = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;
   localparam int ASM_LANES     = (BYTES_PER_WORD < 4) ? BYTES_PER_WORD : 4;

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd1;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd153;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_MARKER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_MARKER   = 2'd1;

   typedef struct packed {
      logic clear;       // restart word and byte counters
      logic take_byte;   // store one payload byte
      logic take_aux;    // store the aux byte
      logic emit_start;  // rewind the emit counter
      logic emit_load;   // load the next result into the output register
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_hit;   // incoming byte equals the start marker
      logic end_hit;     // incoming byte equals the end marker
      logic byte_last;   // incoming byte completes a word
      logic word_last;   // current word is the final word of the frame
      logic emit_last;   // emit counter points at the aux result
      logic out_free;    // output register can take a new result
   } dp_status_type;

endpackage

`default_nettype wire

// File: design/sfd_datapath.sv
// Datapath of the deframer: markers, word assembly, word store and result register.
`default_nettype none
`include "sensor_frame_deframer_top_macros.svh"

module sfd_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire  [sfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [sfd_pkg::BYTE_W-1:0]       csr_wdata,
   input  wire  [sfd_pkg::BYTE_W-1:0]       req_rx_byte,
   input  wire  sfd_pkg::ctrl_cmd_type      cmd,
   output sfd_pkg::dp_status_type           status,
   input  wire                              rsp_stall,
   output logic                             rsp_valid,
   output logic [sfd_pkg::INDEX_W-1:0]      rsp_field_index,
   output logic [sfd_pkg::WORD_W-1:0]       rsp_field_value,
   output logic                             rsp_last
);

   logic [sfd_pkg::BYTE_W-1:0]     start_marker_ff, start_marker_in;
   logic [sfd_pkg::BYTE_W-1:0]     end_marker_ff, end_marker_in;
   logic [sfd_pkg::BYTE_CNT_W-1:0] byte_cnt_ff, byte_cnt_in;
   logic [sfd_pkg::WORD_IDX_W-1:0] word_idx_ff, word_idx_in;
   logic [sfd_pkg::WORD_W-1:0]     asm_ff, asm_in;
   logic [sfd_pkg::WORD_W-1:0]     word_next;
   logic [sfd_pkg::WORD_W-1:0]     word_store_ff [sfd_pkg::NUM_WORDS];
   logic [sfd_pkg::BYTE_W-1:0]     aux_ff;
   logic [sfd_pkg::INDEX_W-1:0]    emit_idx_ff, emit_idx_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sfd_pkg::INDEX_W-1:0]    rsp_index_ff;
   logic [sfd_pkg::WORD_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                           rsp_last_ff, rsp_last_in;

   always_comb begin
      start_marker_in = start_marker_ff;
      end_marker_in   = end_marker_ff;
      if (csr_we) begin
         case (csr_index)
            sfd_pkg::CSR_START_MARKER: start_marker_in = csr_wdata;
            sfd_pkg::CSR_END_MARKER:   end_marker_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Place the incoming byte into its little-endian lane; bytes past the
   // fourth do not reach the 32-bit word.
   always_comb begin
      word_next = asm_ff;
      for (int lane = 0; lane < sfd_pkg::ASM_LANES; lane++) begin
         if (byte_cnt_ff == sfd_pkg::BYTE_CNT_W'(lane)) begin
            word_next[lane*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = req_rx_byte;
         end
      end
   end

   assign status.start_hit = (req_rx_byte == start_marker_ff);
   assign status.end_hit   = (req_rx_byte == end_marker_ff);
   assign status.byte_last = (byte_cnt_ff == sfd_pkg::BYTE_CNT_W'(sfd_pkg::BYTES_PER_WORD - 1));
   assign status.word_last = (word_idx_ff == sfd_pkg::WORD_IDX_W'(sfd_pkg::NUM_WORDS - 1));
   assign status.emit_last = (emit_idx_ff == sfd_pkg::INDEX_W'(sfd_pkg::NUM_WORDS));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      byte_cnt_in = byte_cnt_ff;
      word_idx_in = word_idx_ff;
      asm_in      = asm_ff;
      if (cmd.clear) begin
         byte_cnt_in = '0;
         word_idx_in = '0;
         asm_in      = '0;
      end else if (cmd.take_byte) begin
         if (status.byte_last) begin
            byte_cnt_in = '0;
            asm_in      = '0;
            word_idx_in = word_idx_ff + 1'b1;
         end else begin
            byte_cnt_in = byte_cnt_ff + 1'b1;
            asm_in      = word_next;
         end
      end
   end

   always_comb begin
      emit_idx_in = emit_idx_ff;
      if (cmd.emit_start) begin
         emit_idx_in = '0;
      end else if (cmd.emit_load) begin
         emit_idx_in = emit_idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
         if (status.emit_last) begin
            rsp_value_in = sfd_pkg::WORD_W'(aux_ff);
            rsp_last_in  = 1'b1;
         end else begin
            rsp_value_in = word_store_ff[emit_idx_ff[sfd_pkg::WORD_IDX_W-1:0]];
            rsp_last_in  = 1'b0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= sfd_pkg::START_MARKER_RESET;
         end_marker_ff   <= sfd_pkg::END_MARKER_RESET;
         byte_cnt_ff     <= '0;
         word_idx_ff     <= '0;
         asm_ff          <= '0;
         emit_idx_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         start_marker_ff <= start_marker_in;
         end_marker_ff   <= end_marker_in;
         byte_cnt_ff     <= byte_cnt_in;
         word_idx_ff     <= word_idx_in;
         asm_ff          <= asm_in;
         emit_idx_ff     <= emit_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte && status.byte_last) begin
         word_store_ff[word_idx_ff] <= word_next;
      end
      if (cmd.take_aux) begin
         aux_ff <= req_rx_byte;
      end
      if (cmd.emit_load) begin
         rsp_index_ff <= emit_idx_ff;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_field_index = rsp_index_ff;
   assign rsp_field_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

   `SFD_ASSERT_NOW(a_last_is_aux, rsp_valid_ff && rsp_last_ff,
      rsp_index_ff == sfd_pkg::INDEX_W'(sfd_pkg::NUM_WORDS), "last result is not the aux entry")
   `SFD_ASSERT_NEXT(a_word_not_last, cmd.emit_load && !status.emit_last,
      rsp_valid_ff && !rsp_last_ff, "word result loaded with last set")

endmodule

`default_nettype wire

// File: design/sfd_ctrl.sv
// Frame controller of the deframer: hunt, collect, check and emit sequencing.
`default_nettype none
`include "sensor_frame_deframer_top_macros.svh"

module sfd_ctrl (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  sfd_pkg::dp_status_type  status,
   output sfd_pkg::ctrl_cmd_type         cmd
);

   localparam logic [2:0] ST_HUNT  = 3'd0;
   localparam logic [2:0] ST_WORDS = 3'd1;
   localparam logic [2:0] ST_AUX   = 3'd2;
   localparam logic [2:0] ST_END   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       fire;

   assign req_stall = (state_ff == ST_EMIT);
   assign fire      = req_valid && !req_stall;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      case (state_ff)
         ST_HUNT: begin
            if (fire) begin
               cmd.clear = 1'b1;
               if (status.start_hit) begin
                  state_in = ST_WORDS;
               end
            end
         end
         ST_WORDS: begin
            if (fire) begin
               cmd.take_byte = 1'b1;
               if (status.byte_last && status.word_last) begin
                  state_in = ST_AUX;
               end
            end
         end
         ST_AUX: begin
            if (fire) begin
               cmd.take_aux = 1'b1;
               state_in     = ST_END;
            end
         end
         ST_END: begin
            if (fire) begin
               if (status.end_hit) begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_EMIT;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_HUNT;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   `SFD_ASSERT_NEXT(a_end_ok_emits, state_ff == ST_END && fire && status.end_hit,
      state_ff == ST_EMIT, "good end marker did not start emission")
   `SFD_ASSERT_NEXT(a_emit_done_hunts, state_ff == ST_EMIT && status.out_free && status.emit_last,
      state_ff == ST_HUNT, "emission did not return to hunting")
   `SFD_ASSERT_NEXT(a_words_to_aux,
      state_ff == ST_WORDS && fire && status.byte_last && status.word_last,
      state_ff == ST_AUX, "final word did not advance to aux")

endmodule

`default_nettype wire

// File: design/sensor_frame_deframer_top.sv
// Top level of the sensor frame deframer: controller plus datapath.
//
//   Port group   Direction  Handshake          Carries
//   req_*        in         req_valid/stall    one received byte per transaction
//   rsp_*        out        rsp_valid/stall    one frame field per transaction
//   csr_*        in         csr_we             start/end marker writes
//
// The controller takes received bytes without stalling while the frame is being collected.
// A good end byte yields 13 result transactions, one a cycle unless rsp_stall holds them.
// req_stall is high while those 13 results are loaded, including while rsp_stall holds them.
// Synchronous active-high reset sets the markers to 1 and 153 and returns to hunting.
// A stalled result holds in its register.
`default_nettype none

module sensor_frame_deframer_top (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [sfd_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [sfd_pkg::INDEX_W-1:0]      rsp_field_index,
   output logic [sfd_pkg::WORD_W-1:0]       rsp_field_value,
   output logic                             rsp_last,
   input  wire                              csr_we,
   input  wire  [sfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [sfd_pkg::BYTE_W-1:0]       csr_wdata
);

   // Commands from the controller and status back from the datapath.
   sfd_pkg::ctrl_cmd_type  cmd;
   sfd_pkg::dp_status_type status;

   // The controller owns framing decisions and input flow control.
   sfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds markers, assembled words and the result register.
   sfd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_rx_byte     (req_rx_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_field_index (rsp_field_index),
      .rsp_field_value (rsp_field_value),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
